>>> src/mlpq_pkg.sv
`default_nettype none

package mlpq_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned LEVELS_DEF      = 16;
  localparam int unsigned LEVEL_DEPTH_DEF = 16;
  localparam int unsigned DATA_WIDTH_DEF  = 16;

  // Fixed field widths of the command and result ports.
  localparam int unsigned LEVEL_W = 4;
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned TOTAL_W = 9;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_META,
    S_ENTRY
  } fsm_e;

endpackage

`default_nettype wire

>>> src/mlpq_ram.sv
`default_nettype none

module mlpq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/mlpq_pick.sv
`default_nettype none

module mlpq_pick
  import mlpq_pkg::*;
#(
  parameter int unsigned LEVELS = LEVELS_DEF,
  localparam int unsigned LVL_W = $clog2(LEVELS)
) (
  input  wire logic [LEVELS-1:0] nonempty_i,
  input  wire logic [CFG_W-1:0]  levels_in_use_i,
  output logic                   found_o,
  output logic      [LVL_W-1:0]  idx_o
);

  logic [LEVELS-1:0] cand;

  // Only levels below the configured count compete; the lowest index wins.
  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      cand[i] = nonempty_i[i] && (32'(i) < 32'(levels_in_use_i));
    end
    found_o = |cand;
    idx_o   = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        idx_o = LVL_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/multilevel_priority_fifo_top.sv
`default_nettype none

// Multilevel priority queue: one FIFO per level, level 0 most urgent.
// Command channel: a transaction is taken when start is high and busy is
// low. opcode_i selects enqueue (level_i, item_data_i), dequeue or peek of the
// head of the lowest non-empty level below levels_in_use, or no operation.
// Result channel: strobe_o is high for one cycle with result_data_o,
// served_level_o, status_o and total_count_o; the receiver cannot stall it.
// Configuration: cfg_we_i writes levels_in_use from cfg_wdata_i; the user must
// do so only while idle; the block does not enforce it. Sequencing: enqueue,
// rejected commands, empty dequeues and no-ops pass the metadata state only,
// the result strobe showing on the return to idle. A served dequeue or peek
// also passes the entry state: the level metadata memory is read first, and
// its head pointer then addresses the entry memory. busy stays high until the
// result shows, so no two transactions touch the memories at the same time.
// Reset clears all levels and sets levels_in_use to 16; entry storage is not
// cleared since a slot is only read after it was written.
module multilevel_priority_fifo_top
  import mlpq_pkg::*;
#(
  parameter int unsigned LEVELS      = LEVELS_DEF,
  parameter int unsigned LEVEL_DEPTH = LEVEL_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            opcode_i,
  input  wire logic [LEVEL_W-1:0]    level_i,
  input  wire logic [DATA_WIDTH-1:0] item_data_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i,
  output logic                       strobe_o,
  output logic      [DATA_WIDTH-1:0] result_data_o,
  output logic      [LEVEL_W-1:0]    served_level_o,
  output logic      [1:0]            status_o,
  output logic      [TOTAL_W-1:0]    total_count_o
);

  localparam int unsigned LVL_W  = $clog2(LEVELS);
  localparam int unsigned PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int unsigned CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned TOT_W  = $clog2(LEVELS * LEVEL_DEPTH + 1);
  localparam int unsigned META_W = 2 * PTR_W + CNT_W;
  localparam int unsigned ENT_DEPTH = LEVELS * (2 ** PTR_W);

  fsm_e state_q, state_d;
  op_e  op_q, op_d;
  logic [LVL_W-1:0]      lvl_q, lvl_d;
  logic [LEVEL_W-1:0]    req_lvl_q, req_lvl_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  hit_q, hit_d;
  logic                  mvld_q, mvld_d;
  logic [LEVELS-1:0]     vld_q, vld_d;
  logic [LEVELS-1:0]     ne_q, ne_d;
  logic [TOT_W-1:0]      tot_q, tot_d;
  logic [CFG_W-1:0]      cfg_q;
  logic                  strobe_q, strobe_d;
  logic [DATA_WIDTH-1:0] rdata_q, rdata_d;
  logic [LEVEL_W-1:0]    rlvl_q, rlvl_d;
  status_e               rst_q, rst_d;

  logic                  accept;
  logic                  found;
  logic [LVL_W-1:0]      pick_idx;
  logic                  in_range;
  logic [LVL_W-1:0]      sel_lvl;

  logic                  meta_we;
  logic [META_W-1:0]     meta_wdata;
  logic [META_W-1:0]     meta_rdata;
  logic [PTR_W-1:0]      m_head, m_tail, nxt_head, nxt_tail;
  logic [CNT_W-1:0]      m_cnt;

  logic                  ent_we;
  logic                  ent_re;
  logic [LVL_W+PTR_W-1:0] ent_waddr, ent_raddr;
  logic [DATA_WIDTH-1:0] ent_rdata;

  mlpq_pick #(
    .LEVELS (LEVELS)
  ) u_pick (
    .nonempty_i      (ne_q),
    .levels_in_use_i (cfg_q),
    .found_o         (found),
    .idx_o           (pick_idx)
  );

  mlpq_ram #(
    .WIDTH (META_W),
    .DEPTH (LEVELS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (lvl_q),
    .wdata_i (meta_wdata),
    .re_i    (accept),
    .raddr_i (sel_lvl),
    .rdata_o (meta_rdata)
  );

  mlpq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (ENT_DEPTH)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (data_q),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  assign accept   = start && (state_q == S_IDLE);
  assign busy     = (state_q != S_IDLE);
  assign in_range = (32'(level_i) < 32'(cfg_q)) && (32'(level_i) < LEVELS);
  assign sel_lvl  = (op_e'(opcode_i) == OP_ENQ) ? LVL_W'(level_i) : pick_idx;

  // A level never written since reset reads as empty with zero pointers.
  assign {m_head, m_tail, m_cnt} = mvld_q ? meta_rdata : '0;
  assign nxt_head = (m_head == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : m_head + 1'b1;
  assign nxt_tail = (m_tail == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : m_tail + 1'b1;
  assign ent_waddr = {lvl_q, m_tail};
  assign ent_raddr = {lvl_q, m_head};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      vld_q    <= '0;
      ne_q     <= '0;
      tot_q    <= '0;
      cfg_q    <= CFG_RESET;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      vld_q    <= vld_d;
      ne_q     <= ne_d;
      tot_q    <= tot_d;
      strobe_q <= strobe_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    lvl_q     <= lvl_d;
    req_lvl_q <= req_lvl_d;
    data_q    <= data_d;
    hit_q     <= hit_d;
    mvld_q    <= mvld_d;
    rdata_q   <= rdata_d;
    rlvl_q    <= rlvl_d;
    rst_q     <= rst_d;
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    lvl_d      = lvl_q;
    req_lvl_d  = req_lvl_q;
    data_d     = data_q;
    hit_d      = hit_q;
    mvld_d     = mvld_q;
    vld_d      = vld_q;
    ne_d       = ne_q;
    tot_d      = tot_q;
    strobe_d   = 1'b0;
    rdata_d    = rdata_q;
    rlvl_d     = rlvl_q;
    rst_d      = rst_q;
    meta_we    = 1'b0;
    meta_wdata = {m_head, m_tail, m_cnt};
    ent_we     = 1'b0;
    ent_re     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d      = op_e'(opcode_i);
          lvl_d     = sel_lvl;
          req_lvl_d = level_i;
          data_d    = item_data_i;
          hit_d     = (op_e'(opcode_i) == OP_ENQ) ? in_range : found;
          mvld_d    = vld_q[sel_lvl];
          state_d   = S_META;
        end
      end

      S_META: begin
        rdata_d = '0;
        rlvl_d  = '0;
        rst_d   = ST_OK;
        state_d = S_IDLE;
        case (op_q) inside
          OP_ENQ: begin
            strobe_d = 1'b1;
            rlvl_d   = req_lvl_q;
            if (!hit_q) begin
              rst_d = ST_RANGE;
            end else if (m_cnt == CNT_W'(LEVEL_DEPTH)) begin
              rst_d = ST_FULL;
            end else begin
              ent_we        = 1'b1;
              meta_we       = 1'b1;
              meta_wdata    = {m_head, nxt_tail, m_cnt + 1'b1};
              vld_d[lvl_q]  = 1'b1;
              ne_d[lvl_q]   = 1'b1;
              tot_d         = tot_q + 1'b1;
            end
          end
          OP_DEQ, OP_PEEK: begin
            if (!hit_q) begin
              strobe_d = 1'b1;
              rst_d    = ST_EMPTY;
            end else begin
              ent_re  = 1'b1;
              state_d = S_ENTRY;
              if (op_q == OP_DEQ) begin
                meta_we    = 1'b1;
                meta_wdata = {nxt_head, m_tail, m_cnt - 1'b1};
                tot_d      = tot_q - 1'b1;
                if (m_cnt == CNT_W'(1)) begin
                  ne_d[lvl_q] = 1'b0;
                end
              end
            end
          end
          default: begin
            strobe_d = 1'b1;
          end
        endcase
      end

      S_ENTRY: begin
        strobe_d = 1'b1;
        rdata_d  = ent_rdata;
        rlvl_d   = LEVEL_W'(lvl_q);
        rst_d    = ST_OK;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign strobe_o       = strobe_q;
  assign result_data_o  = rdata_q;
  assign served_level_o = rlvl_q;
  assign status_o       = rst_q;
  assign total_count_o  = TOTAL_W'(tot_q);

endmodule

`default_nettype wire

>>> src/mlpq_checker.sv
`default_nettype none

module mlpq_checker
  import mlpq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  strobe_o,
  input wire logic [DATA_WIDTH-1:0] result_data_o,
  input wire logic [LEVEL_W-1:0]    served_level_o,
  input wire logic [1:0]            status_o
);

  // An accepted transaction keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // A result is shown exactly in the cycle the block leaves its busy phase.
  a_strobe_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy && $past(busy))
    else $error("result strobe outside the end of a transaction");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("two results in consecutive cycles");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && status_o == ST_EMPTY |-> result_data_o == '0 && served_level_o == '0)
    else $error("empty result carries data or a level");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (status_o == ST_RANGE || status_o == ST_FULL) |-> result_data_o == '0)
    else $error("rejected enqueue carries data");

endmodule

bind multilevel_priority_fifo_top mlpq_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_mlpq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .strobe_o       (strobe_o),
  .result_data_o  (result_data_o),
  .served_level_o (served_level_o),
  .status_o       (status_o)
);

`default_nettype wire

>>> test/multilevel_priority_fifo_top_test.sv
module multilevel_priority_fifo_top_test;
  import mlpq_pkg::*;

  localparam int unsigned LEVELS      = LEVELS_DEF;
  localparam int unsigned LEVEL_DEPTH = LEVEL_DEPTH_DEF;
  localparam int unsigned DATA_WIDTH  = DATA_WIDTH_DEF;
  localparam int          CYCLE_LIMIT = 100000;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] data;
    logic [LEVEL_W-1:0]    lvl;
    status_e               st;
    logic [TOTAL_W-1:0]    total;
  } queue_result_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  logic [1:0]            opcode_i    = OP_NOP;
  logic [LEVEL_W-1:0]    level_i     = '0;
  logic [DATA_WIDTH-1:0] item_data_i = '0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;
  logic                  strobe_o;
  logic [DATA_WIDTH-1:0] result_data_o;
  logic [LEVEL_W-1:0]    served_level_o;
  logic [1:0]            status_o;
  logic [TOTAL_W-1:0]    total_count_o;

  // Predicted contents of the queue, one FIFO per level.
  logic [DATA_WIDTH-1:0] level_items[LEVELS][$];
  int                    items_held     = 0;
  logic [CFG_W-1:0]      levels_setting = CFG_RESET;
  queue_result_t         expected_results[$];
  int                    error_count    = 0;
  int                    cycle_count    = 0;
  bit                    no_gaps        = 1'b0;

  multilevel_priority_fifo_top #(
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .level_i        (level_i),
    .item_data_i    (item_data_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .strobe_o       (strobe_o),
    .result_data_o  (result_data_o),
    .served_level_o (served_level_o),
    .status_o       (status_o),
    .total_count_o  (total_count_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multilevel_priority_fifo_top_test failed");
      $finish;
    end
  end

  function automatic int active_levels();
    return (levels_setting > LEVELS) ? LEVELS : int'(levels_setting);
  endfunction

  // Applies one command to the predicted queue and returns its result.
  function automatic queue_result_t apply_command(op_e op, logic [LEVEL_W-1:0] lvl,
                                                  logic [DATA_WIDTH-1:0] data);
    queue_result_t r;
    int            active;
    bit            found;
    r      = '0;
    r.st   = ST_OK;
    active = active_levels();
    found  = 1'b0;
    case (op) inside
      OP_ENQ: begin
        r.lvl = lvl;
        if (int'(lvl) >= active) begin
          r.st = ST_RANGE;
        end else if (level_items[lvl].size() >= LEVEL_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          level_items[lvl].push_back(data);
          items_held++;
        end
      end
      OP_DEQ, OP_PEEK: begin
        for (int i = 0; i < active; i++) begin
          if (!found && level_items[i].size() > 0) begin
            found  = 1'b1;
            r.lvl  = LEVEL_W'(i);
            r.data = level_items[i][0];
            if (op == OP_DEQ) begin
              void'(level_items[i].pop_front());
              items_held--;
            end
          end
        end
        if (!found) r.st = ST_EMPTY;
      end
      default: begin
      end
    endcase
    r.total = TOTAL_W'(items_held);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  always @(posedge clk_i) begin : check_results
    queue_result_t want;
    if (rst_ni && strobe_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result strobe with no transaction outstanding");
      end else begin
        want = expected_results.pop_front();
        if (result_data_o !== want.data)
          report_mismatch($sformatf("result_data %h, expected %h", result_data_o, want.data));
        if (served_level_o !== want.lvl)
          report_mismatch($sformatf("served_level %0d, expected %0d",
                                    served_level_o, want.lvl));
        if (status_o !== want.st)
          report_mismatch($sformatf("status %0d, expected %s", status_o, want.st.name()));
        if (total_count_o !== want.total)
          report_mismatch($sformatf("total_count %0d, expected %0d",
                                    total_count_o, want.total));
      end
    end
  end

  // Sends one command. Start stays high after acceptance so that a command
  // that follows without a gap is offered in the very next cycle.
  task automatic send_command(op_e op, logic [LEVEL_W-1:0] lvl,
                              logic [DATA_WIDTH-1:0] data);
    int gap;
    if ($urandom_range(0, 40) == 0) no_gaps = ~no_gaps;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    opcode_i    <= op;
    level_i     <= lvl;
    item_data_i <= data;
    do @(posedge clk_i); while (busy);
    expected_results.push_back(apply_command(op, lvl, data));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_levels(logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    levels_setting = value;
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed();
    // Empty queue and no-operation right after reset.
    send_command(OP_DEQ, 4'hF, 16'hFFFF);
    send_command(OP_PEEK, 4'h0, 16'h0000);
    send_command(OP_NOP, 4'hA, 16'h5A5A);
    send_command(OP_ENQ, 4'd15, 16'hFFFF);
    send_command(OP_ENQ, 4'd0, 16'h0000);
    send_command(OP_ENQ, 4'd7, 16'hA5A5);
    send_command(OP_PEEK, 4'd9, 16'h1234);
    send_command(OP_DEQ, 4'd0, 16'h0000);
    send_command(OP_DEQ, 4'd0, 16'h0000);
    send_command(OP_NOP, 4'd0, 16'h0000);
    send_command(OP_DEQ, 4'd0, 16'h0000);
    send_command(OP_DEQ, 4'd0, 16'h0000);
    // Fewer levels: enqueues at or above the limit are rejected.
    write_levels(5'd4);
    send_command(OP_ENQ, 4'd4, 16'h1111);
    send_command(OP_ENQ, 4'd3, 16'h3C3C);
    send_command(OP_ENQ, 4'd15, 16'h2222);
    // No levels at all: the stored item is held but hidden.
    write_levels(5'd0);
    send_command(OP_ENQ, 4'd0, 16'h3333);
    send_command(OP_PEEK, 4'd0, 16'h0000);
    send_command(OP_DEQ, 4'd0, 16'h0000);
    // Values above the level count saturate.
    write_levels(5'd31);
    send_command(OP_ENQ, 4'd15, 16'hC3C3);
    send_command(OP_DEQ, 4'd0, 16'h0000);
    send_command(OP_DEQ, 4'd0, 16'h0000);
    write_levels(5'd1);
    send_command(OP_ENQ, 4'd0, 16'h8001);
    send_command(OP_ENQ, 4'd1, 16'h7FFE);
    send_command(OP_DEQ, 4'd0, 16'h0000);
  endtask

  // Fills every level to capacity, overflows one, then drains everything so
  // that every pointer wraps and the total reaches its maximum.
  task automatic test_fill_and_drain();
    write_levels(5'd16);
    for (int l = LEVELS - 1; l >= 0; l--) begin
      for (int k = 0; k < LEVEL_DEPTH; k++) begin
        send_command(OP_ENQ, LEVEL_W'(l), DATA_WIDTH'($urandom));
      end
    end
    send_command(OP_ENQ, LEVEL_W'($urandom_range(0, LEVELS - 1)), DATA_WIDTH'($urandom));
    for (int k = 0; k < LEVELS * LEVEL_DEPTH + 1; k++) begin
      if ($urandom_range(0, 7) == 0)
        send_command(OP_PEEK, LEVEL_W'($urandom), DATA_WIDTH'($urandom));
      send_command(OP_DEQ, LEVEL_W'($urandom), DATA_WIDTH'($urandom));
    end
  endtask

  task automatic test_random_phases();
    logic [CFG_W-1:0]      phase_levels[7] = '{5'd16, 5'd5, 5'd1, 5'd31, 5'd0, 5'd12, 5'd2};
    int                    enq_pct;
    int                    roll;
    op_e                   op;
    logic [LEVEL_W-1:0]    lvl;
    for (int p = 0; p < 7; p++) begin
      write_levels(p < 4 ? phase_levels[p] : CFG_W'($urandom_range(0, 31)));
      if (p >= 4 && $urandom_range(0, 1) == 0) write_levels(phase_levels[p]);
      // Alternate between filling and draining so both full and empty
      // levels show up often.
      enq_pct = (p % 2 == 0) ? 70 : 35;
      for (int k = 0; k < 45; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < enq_pct) op = OP_ENQ;
        else if (roll < 97) op = ($urandom_range(0, 2) == 0) ? OP_PEEK : OP_DEQ;
        else op = OP_NOP;
        if ($urandom_range(0, 4) == 0 || active_levels() == 0)
          lvl = LEVEL_W'($urandom_range(0, 15));
        else
          lvl = LEVEL_W'($urandom_range(0, active_levels() - 1));
        send_command(op, lvl, DATA_WIDTH'($urandom));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_and_drain();
    test_random_phases();
    wait_drained();
    if (error_count == 0) begin
      $display("multilevel_priority_fifo_top_test passed");
    end else begin
      $display("multilevel_priority_fifo_top_test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/mlpq_pkg.sv
src/mlpq_ram.sv
src/mlpq_pick.sv
src/multilevel_priority_fifo_top.sv
src/mlpq_checker.sv
test/multilevel_priority_fifo_top_test.sv
